// ===== hdl/csfd_pkg.sv =====
// ----------------------------------------------------------------------------
// csfd_pkg
// Shared types, constants and the 8b10b code table for the comma-aligned
// frame decoder.
// ----------------------------------------------------------------------------
package csfd_pkg;

  localparam int SYM_W        = 10;
  localparam int BYTE_W       = 8;
  localparam int IDX_W        = 12;
  localparam int CFG_ADDR_W   = 8;
  localparam int CFG_DATA_W   = 13;
  localparam int CODE_ENTRIES = 256;
  localparam int DIST_W       = 4;

  localparam logic [CFG_ADDR_W-1:0] REG_COMMA_PATTERN = 8'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WORDS   = 8'd1;

  localparam logic [SYM_W-1:0]      COMMA_RESET  = 10'd380;
  localparam logic [CFG_DATA_W-1:0] FRAME_RESET  = 13'd256;
  localparam logic [3:0]            BIT_LAST     = 4'd9;
  localparam logic [DIST_W-1:0]     DIST_INIT    = 4'd11;
  localparam logic [DIST_W-1:0]     DIST_FOLD    = 4'd5;
  localparam logic [DIST_W-1:0]     DIST_SPAN    = 4'd10;
  localparam logic [BYTE_W-1:0]     ENTRY_LAST   = 8'(CODE_ENTRIES - 1);

  localparam logic [5:0] SIX_MINUS [32] = '{
    6'h27, 6'h1D, 6'h2D, 6'h31, 6'h35, 6'h29, 6'h19, 6'h38,
    6'h39, 6'h25, 6'h15, 6'h34, 6'h0D, 6'h2C, 6'h1C, 6'h17,
    6'h1B, 6'h23, 6'h13, 6'h32, 6'h0B, 6'h2A, 6'h1A, 6'h3A,
    6'h33, 6'h26, 6'h16, 6'h36, 6'h0E, 6'h2E, 6'h1E, 6'h2B
  };

  // entry 8 is the alternate A7 code
  localparam logic [3:0] FOUR_MINUS [9] = '{
    4'hB, 4'h9, 4'h5, 4'hC, 4'hD, 4'hA, 4'h6, 4'hE, 4'h7
  };
  localparam logic [3:0] FOUR_PLUS [9] = '{
    4'h4, 4'h9, 4'h5, 4'h3, 4'h2, 4'hA, 4'h6, 4'h1, 4'h8
  };

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_SEARCH
  } state_t;

  typedef struct packed {
    logic             start;
    logic             take;
    logic [SYM_W-1:0] target;
  } srch_req_t;

  typedef struct packed {
    logic              busy;
    logic              res_valid;
    logic [BYTE_W-1:0] pos;
    logic              erasure;
  } srch_rsp_t;

  // ten-bit code for a byte, running disparity minus, abcdei fghj msb first
  function automatic logic [SYM_W-1:0] rom_code(input logic [BYTE_W-1:0] idx);
    logic [4:0] x;
    logic [2:0] y;
    logic [5:0] six;
    logic [2:0] ones;
    logic       rd_plus;
    logic [3:0] sel;
    logic [3:0] four;
    x    = idx[4:0];
    y    = idx[7:5];
    six  = SIX_MINUS[x];
    ones = 3'd0;
    for (int k = 0; k < 6; k++) begin
      ones = ones + {2'b00, six[k]};
    end
    rd_plus = (ones != 3'd3);
    sel     = {1'b0, y};
    if (y == 3'd7) begin
      if ((!rd_plus && (x == 5'd17 || x == 5'd18 || x == 5'd20)) ||
          (rd_plus && (x == 5'd11 || x == 5'd13 || x == 5'd14))) begin
        sel = 4'd8;
      end
    end
    four = rd_plus ? FOUR_PLUS[sel] : FOUR_MINUS[sel];
    return {six, four};
  endfunction

endpackage

// ===== hdl/csfd_if.sv =====
// ----------------------------------------------------------------------------
// csfd_if
// Valid/ready channels of the frame decoder: line bits, decoded words and
// configuration writes.
// ----------------------------------------------------------------------------
interface csfd_in_if;
  logic valid;
  logic ready;
  logic rx_bit;

  modport source (output valid, output rx_bit, input ready);
  modport sink   (input valid, input rx_bit, output ready);
endinterface

interface csfd_out_if;
  import csfd_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] decoded_byte;
  logic              erasure;
  logic [IDX_W-1:0]  word_index;
  logic              frame_last;

  modport source (output valid, output decoded_byte, output erasure,
                  output word_index, output frame_last, input ready);
  modport sink   (input valid, input decoded_byte, input erasure,
                  input word_index, input frame_last, output ready);
endinterface

interface csfd_cfg_if;
  import csfd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

// ===== hdl/comma_sync_8b10b_frame_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// comma_sync_8b10b_frame_decoder_unit
// Hunting and the first nine bits of a word: one transfer per cycle, no result.
// Tenth bit: the search steps through the code table one entry at a time until
// an exact match or the last entry, then the output register loads once its
// slot is free; input is stalled while searching and while the result is held.
// Synchronous active-high reset: hunting, counters clear, config regs default.
// ----------------------------------------------------------------------------
module comma_sync_8b10b_frame_decoder_unit #(
  parameter int MAX_FRAME_WORDS = 4096
) (
  input  logic       clk,
  input  logic       rst,
  csfd_in_if.sink    rx,
  csfd_out_if.source res,
  csfd_cfg_if.sink   cfg
);
  import csfd_pkg::*;

  localparam int CNT_W = $clog2(MAX_FRAME_WORDS + 1);
  localparam int LW    = (CNT_W > CFG_DATA_W) ? CNT_W : CFG_DATA_W;

  logic [SYM_W-1:0]      comma_pattern;
  logic [CFG_DATA_W-1:0] frame_words;

  state_t           state, state_next;
  logic [SYM_W-1:0] comma_shift, comma_shift_next;
  logic             decoding_mode, decoding_mode_next;
  logic [3:0]       bit_position, bit_position_next;
  logic [SYM_W-1:0] word_assembly, word_assembly_next;
  logic [CNT_W-1:0] word_count, word_count_next;

  logic              out_valid;
  logic [BYTE_W-1:0] out_byte;
  logic              out_erasure;
  logic [IDX_W-1:0]  out_index;
  logic              out_last;

  logic [SYM_W-1:0] shift_val;
  logic [SYM_W-1:0] asm_val;
  logic [LW-1:0]    fw_ext;
  logic [LW-1:0]    len_eff;
  logic [LW-1:0]    count_inc;
  logic             frame_end;
  logic             slot_free;
  logic             load;

  srch_req_t sreq;
  srch_rsp_t srsp;

  csfd_search u_search (
    .clk (clk),
    .rst (rst),
    .req (sreq),
    .rsp (srsp)
  );

  // configuration
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      comma_pattern <= COMMA_RESET;
      frame_words   <= FRAME_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.addr)
        REG_COMMA_PATTERN: comma_pattern <= cfg.data[SYM_W-1:0];
        REG_FRAME_WORDS:   frame_words   <= cfg.data;
        default: ;
      endcase
    end
  end

  // effective frame length
  assign fw_ext    = LW'(frame_words);
  assign len_eff   = (fw_ext == '0) ? LW'(1) :
                     (fw_ext > LW'(MAX_FRAME_WORDS)) ? LW'(MAX_FRAME_WORDS) : fw_ext;
  assign count_inc = LW'(word_count) + LW'(1);
  assign frame_end = (count_inc >= len_eff);

  assign shift_val = {comma_shift[SYM_W-2:0], rx.rx_bit};
  assign asm_val   = {word_assembly[SYM_W-2:0], rx.rx_bit};
  assign slot_free = !out_valid || res.ready;

  assign rx.ready    = (state == ST_IDLE);

  always_comb begin
    state_next         = state;
    comma_shift_next   = comma_shift;
    decoding_mode_next = decoding_mode;
    bit_position_next  = bit_position;
    word_assembly_next = word_assembly;
    word_count_next    = word_count;
    sreq.start         = 1'b0;
    sreq.take          = 1'b0;
    sreq.target        = asm_val;
    load               = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (rx.valid) begin
          if (!decoding_mode) begin
            comma_shift_next = shift_val;
            if (shift_val == comma_pattern || shift_val == ~comma_pattern) begin
              decoding_mode_next = 1'b1;
              word_count_next    = '0;
              bit_position_next  = '0;
              word_assembly_next = '0;
            end
          end else begin
            word_assembly_next = asm_val;
            if (bit_position == BIT_LAST) begin
              bit_position_next = '0;
              sreq.start        = 1'b1;
              state_next        = ST_SEARCH;
            end else begin
              bit_position_next = bit_position + 4'd1;
            end
          end
        end
      end
      ST_SEARCH: begin
        if (srsp.res_valid && slot_free) begin
          load       = 1'b1;
          sreq.take  = 1'b1;
          state_next = ST_IDLE;
          if (frame_end) begin
            word_count_next    = '0;
            decoding_mode_next = 1'b0;
          end else begin
            word_count_next = CNT_W'(count_inc);
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      comma_shift   <= '0;
      decoding_mode <= 1'b0;
      bit_position  <= '0;
      word_assembly <= '0;
      word_count    <= '0;
    end else begin
      state         <= state_next;
      comma_shift   <= comma_shift_next;
      decoding_mode <= decoding_mode_next;
      bit_position  <= bit_position_next;
      word_assembly <= word_assembly_next;
      word_count    <= word_count_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte    <= srsp.pos;
      out_erasure <= srsp.erasure;
      out_index   <= IDX_W'(word_count);
      out_last    <= frame_end;
    end
  end

  assign res.valid        = out_valid;
  assign res.decoded_byte = out_byte;
  assign res.erasure      = out_erasure;
  assign res.word_index   = out_index;
  assign res.frame_last   = out_last;

`ifndef SYNTHESIS
  a_start_only_decoding: assert property (@(posedge clk) disable iff (rst)
    sreq.start |-> decoding_mode)
    else $error("search started while hunting");

  a_hunt_bit_pos_clear: assert property (@(posedge clk) disable iff (rst)
    !decoding_mode |-> (bit_position == '0))
    else $error("bit position not clear while hunting");

  a_frame_end_hunts: assert property (@(posedge clk) disable iff (rst)
    (load && frame_end) |=> (!decoding_mode && word_count == '0))
    else $error("hunting did not resume after last word");

  a_search_idle_on_load: assert property (@(posedge clk) disable iff (rst)
    load |-> !srsp.busy)
    else $error("result taken while search still running");
`endif

endmodule

// ===== hdl/csfd_search.sv =====
// ----------------------------------------------------------------------------
// csfd_search
// Nearest-codeword search: one code table entry per cycle through a shared
// xor, popcount, fold and compare unit, stopping at an exact match or the last entry.
// ----------------------------------------------------------------------------
module csfd_search (
  input  logic                clk,
  input  logic                rst,
  input  csfd_pkg::srch_req_t req,
  output csfd_pkg::srch_rsp_t rsp
);
  import csfd_pkg::*;

  logic              busy;
  logic              res_valid;
  logic [BYTE_W-1:0] idx;
  logic [SYM_W-1:0]  target;
  logic [BYTE_W-1:0] best_pos;
  logic [DIST_W-1:0] best_dist;

  logic [SYM_W-1:0]  diff;
  logic [DIST_W-1:0] ones;
  logic [DIST_W-1:0] fold_dist;
  logic              better;
  logic              stop;

  assign diff = target ^ rom_code(idx);

  always_comb begin
    ones = '0;
    for (int k = 0; k < SYM_W; k++) begin
      ones = ones + {{(DIST_W-1){1'b0}}, diff[k]};
    end
  end

  assign fold_dist = (ones > DIST_FOLD) ? (DIST_SPAN - ones) : ones;
  assign better    = (fold_dist < best_dist);
  assign stop      = (fold_dist == '0) || (idx == ENTRY_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      res_valid <= 1'b0;
    end else if (req.start) begin
      busy      <= 1'b1;
      res_valid <= 1'b0;
      idx       <= '0;
      best_pos  <= '0;
      best_dist <= DIST_INIT;
      target    <= req.target;
    end else if (busy) begin
      if (better) begin
        best_pos  <= idx;
        best_dist <= fold_dist;
      end
      if (stop) begin
        busy      <= 1'b0;
        res_valid <= 1'b1;
      end
      idx <= idx + 1'b1;
    end else if (req.take) begin
      res_valid <= 1'b0;
    end
  end

  assign rsp.busy      = busy;
  assign rsp.res_valid = res_valid;
  assign rsp.pos       = best_pos;
  assign rsp.erasure   = (best_dist != '0);

endmodule
